### rtl/pixel_to_ansi_truecolor_encoder_assert.svh
// Assertion macros for the ANSI truecolor encoder.
// Included by the top level; no other dependencies.
`ifndef PIXEL_TO_ANSI_TRUECOLOR_ENCODER_ASSERT_SVH
`define PIXEL_TO_ANSI_TRUECOLOR_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define P2A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define P2A_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define P2A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define P2A_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/p2a_pkg.sv
// Shared types and constants for the ANSI truecolor encoder.
// No dependencies.
`timescale 1ns / 1ps

package p2a_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } char_t;

  // Output sequence segments, in emit order.
  typedef enum logic [2:0] {
    SEG_HOME,
    SEG_BG,
    SEG_SP,
    SEG_ROW,
    SEG_FRAME
  } seg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam int unsigned OffW = 5;

  typedef struct packed {
    logic            load;
    logic            emit;
    logic            last;
    seg_e            seg;
    logic [OffW-1:0] off;
  } cmd_t;

  typedef struct packed {
    logic frame_start;  // next pixel opens a frame
    logic bg_now;       // incoming pixel needs a color sequence
    logic bg;           // latched request needs a color sequence
    logic row;
    logic frame;
    logic out_free;
  } status_t;

  localparam logic [7:0] ChEsc    = 8'h1B;
  localparam logic [7:0] ChLbrk   = 8'h5B;
  localparam logic [7:0] ChH      = 8'h48;
  localparam logic [7:0] ChK      = 8'h4B;
  localparam logic [7:0] ChM      = 8'h6D;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChFour   = 8'h34;
  localparam logic [7:0] ChEight  = 8'h38;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChNl     = 8'h0A;

  // Offset of the final byte of each segment.
  function automatic logic [OffW-1:0] seg_last(seg_e seg);
    logic [OffW-1:0] r;
    case (seg)
      SEG_HOME:  r = OffW'(2);
      SEG_BG:    r = OffW'(18);
      SEG_SP:    r = OffW'(1);
      SEG_ROW:   r = OffW'(7);
      SEG_FRAME: r = OffW'(3);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/p2a_ctrl.sv
// Byte sequencer control: walks the segments of one pixel's byte stream.
// Depends on p2a_pkg.
`timescale 1ns / 1ps

module p2a_ctrl
  import p2a_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e          state_q, state_d;
  seg_e            seg_q, seg_d;
  logic [OffW-1:0] off_q, off_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seg_q   <= SEG_HOME;
      off_q   <= '0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      off_q   <= off_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    seg_d      = seg_q;
    off_d      = off_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, emit: 1'b0, last: 1'b0, seg: seg_q, off: off_q};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          off_d      = '0;
          state_d    = ST_RUN;
          if (status_i.frame_start) seg_d = SEG_HOME;
          else if (status_i.bg_now) seg_d = SEG_BG;
          else                      seg_d = SEG_SP;
        end
      end
      ST_RUN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (off_q == seg_last(seg_q)) begin
            off_d = '0;
            case (seg_q)
              SEG_HOME: seg_d = status_i.bg ? SEG_BG : SEG_SP;
              SEG_BG:   seg_d = SEG_SP;
              SEG_SP: begin
                if (status_i.row)        seg_d = SEG_ROW;
                else if (status_i.frame) seg_d = SEG_FRAME;
                else begin
                  cmd_o.last = 1'b1;
                  state_d    = ST_IDLE;
                end
              end
              SEG_ROW: begin
                if (status_i.frame) seg_d = SEG_FRAME;
                else begin
                  cmd_o.last = 1'b1;
                  state_d    = ST_IDLE;
                end
              end
              default: begin
                cmd_o.last = 1'b1;
                state_d    = ST_IDLE;
              end
            endcase
          end else begin
            off_d = off_q + OffW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/p2a_dp.sv
// Datapath: pixel latch, color/frame state, decimal digits, byte select
// and the output register. Depends on p2a_pkg.
`timescale 1ns / 1ps

module p2a_dp
  import p2a_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pixel_t  in_pixel_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output char_t   out_char_o
);

  logic [23:0] last_color_q;
  logic        stale_q, frame_start_q;
  logic        bg_q, row_q, frame_q;
  logic [3:0]  dig_q [9];
  logic        out_valid_q;
  char_t       out_q;
  logic [23:0] color;
  logic [3:0]  dig_d [9];
  logic [7:0]  byte_sel;

  // 8-bit value to three BCD digits; tens via multiply by 205 / 2048.
  function automatic logic [11:0] to_dec3(logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = 7'(v - 8'd100);
    end else begin
      h = 2'd0;
      r = v[6:0];
    end
    p = {8'b0, r} * 15'd205;
    t = p[14:11];
    o = r - {t, 3'b0} - {2'b0, t, 1'b0};
    return {2'b0, h, t, o[3:0]};
  endfunction

  assign color = {in_pixel_i.red, in_pixel_i.green, in_pixel_i.blue};

  always_comb begin
    logic [11:0] dr, dg, db;
    dr = to_dec3(in_pixel_i.red);
    dg = to_dec3(in_pixel_i.green);
    db = to_dec3(in_pixel_i.blue);
    dig_d[0] = dr[11:8]; dig_d[1] = dr[7:4]; dig_d[2] = dr[3:0];
    dig_d[3] = dg[11:8]; dig_d[4] = dg[7:4]; dig_d[5] = dg[3:0];
    dig_d[6] = db[11:8]; dig_d[7] = db[7:4]; dig_d[8] = db[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_color_q  <= '0;
      stale_q       <= 1'b1;
      frame_start_q <= 1'b1;
      bg_q          <= 1'b0;
      row_q         <= 1'b0;
      frame_q       <= 1'b0;
    end else if (cmd_i.load) begin
      last_color_q  <= color;
      stale_q       <= in_pixel_i.row_end | in_pixel_i.frame_end;
      frame_start_q <= in_pixel_i.frame_end;
      bg_q          <= status_o.bg_now;
      row_q         <= in_pixel_i.row_end;
      frame_q       <= in_pixel_i.frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 9; i++) begin
        dig_q[i] <= dig_d[i];
      end
    end
  end

  always_comb begin
    byte_sel = ChSpace;
    case (cmd_i.seg)
      SEG_HOME: begin
        case (cmd_i.off)
          5'd0:    byte_sel = ChEsc;
          5'd1:    byte_sel = ChLbrk;
          default: byte_sel = ChH;
        endcase
      end
      SEG_BG: begin
        case (cmd_i.off)
          5'd0:    byte_sel = ChEsc;
          5'd1:    byte_sel = ChLbrk;
          5'd2:    byte_sel = ChFour;
          5'd3:    byte_sel = ChEight;
          5'd4:    byte_sel = ChSemi;
          5'd5:    byte_sel = ChTwo;
          5'd6:    byte_sel = ChSemi;
          5'd7:    byte_sel = ChZero | {4'b0, dig_q[0]};
          5'd8:    byte_sel = ChZero | {4'b0, dig_q[1]};
          5'd9:    byte_sel = ChZero | {4'b0, dig_q[2]};
          5'd10:   byte_sel = ChSemi;
          5'd11:   byte_sel = ChZero | {4'b0, dig_q[3]};
          5'd12:   byte_sel = ChZero | {4'b0, dig_q[4]};
          5'd13:   byte_sel = ChZero | {4'b0, dig_q[5]};
          5'd14:   byte_sel = ChSemi;
          5'd15:   byte_sel = ChZero | {4'b0, dig_q[6]};
          5'd16:   byte_sel = ChZero | {4'b0, dig_q[7]};
          5'd17:   byte_sel = ChZero | {4'b0, dig_q[8]};
          default: byte_sel = ChM;
        endcase
      end
      SEG_SP: byte_sel = ChSpace;
      SEG_ROW: begin
        case (cmd_i.off)
          5'd0, 5'd4: byte_sel = ChEsc;
          5'd1, 5'd5: byte_sel = ChLbrk;
          5'd2:       byte_sel = ChZero;
          5'd3:       byte_sel = ChM;
          5'd6:       byte_sel = ChK;
          default:    byte_sel = ChNl;
        endcase
      end
      SEG_FRAME: begin
        case (cmd_i.off)
          5'd0:    byte_sel = ChEsc;
          5'd1:    byte_sel = ChLbrk;
          5'd2:    byte_sel = ChZero;
          default: byte_sel = ChM;
        endcase
      end
      default: byte_sel = ChSpace;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= '{out_byte: byte_sel, last_byte: cmd_i.last};
    end
  end

  assign status_o.frame_start = frame_start_q;
  assign status_o.bg_now      = stale_q | (color != last_color_q);
  assign status_o.bg          = bg_q;
  assign status_o.row         = row_q;
  assign status_o.frame       = frame_q;
  assign status_o.out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_q;

endmodule

### rtl/pixel_to_ansi_truecolor_encoder.sv
// ANSI truecolor encoder: one RGB pixel in, a stream of terminal bytes out.
//
// Input channel in_valid_i/in_ready_o carries one pixel_t per request: the
// color and the row-end / frame-end marks. Output channel out_valid_o /
// out_ready_i carries one char_t per request: a byte and a last_byte flag
// set on the final byte of each pixel.
// A pixel yields 2 to 36 bytes: cursor home (3) on the first pixel of a
// frame, a background color sequence (19) when the color changed or after
// a row/frame end, two spaces, a row trailer (8) on a row end and a frame
// trailer (4) on a frame end. The byte sequencer emits one byte per cycle
// while the output is not stalled; the pixel is latched when it is taken,
// and the sequencer then emits its first byte into the output register.
// A new pixel is taken once the final byte of the previous one sits in
// the output register. A stall on the output holds the sequencer; no byte
// is dropped. Reset empties the output register and marks the color stale
// and the next pixel as a frame start.
// Depends on p2a_pkg, p2a_ctrl, p2a_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "pixel_to_ansi_truecolor_encoder_assert.svh"

module pixel_to_ansi_truecolor_encoder
  import p2a_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pixel_t in_pixel_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output char_t  out_char_o
);

  cmd_t    cmd;
  status_t status;

  p2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  p2a_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_pixel_i  (in_pixel_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o)
  );

  `P2A_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `P2A_ASSERT_IMP(a_no_accept_midpixel, clk_i, rst_ni, out_valid_o && !out_char_o.last_byte, !in_ready_o, "ready mid-pixel")
  `P2A_ASSERT_IMP(a_ready_after_last, clk_i, rst_ni, $rose(in_ready_o), out_valid_o && out_char_o.last_byte, "ready without last byte")

endmodule
